// ===== sv/ils_pkg.sv =====
package ils_pkg;

    localparam int MAX_LEN = 255;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_INT     = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_BAD     = 2'd2,
        ST_FLOAT   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ZERO    = 3'd1,
        PH_PREFIX  = 3'd2,
        PH_DIGITS  = 3'd3,
        PH_DOT     = 3'd4,
        PH_SUFFIX  = 3'd5,
        PH_SUFFIX2 = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_OCT = 2'd2,
        RX_BIN = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        SFX_NONE = 2'd0,
        SFX_16   = 2'd1,
        SFX_32   = 2'd2,
        SFX_64   = 2'd3
    } sfx_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] value;
        logic        is_unsigned;
        logic [6:0]  bit_width;
        logic [7:0]  consumed_length;
    } out_beat_t;

    function automatic logic [7:0] len8(input cnt_t len);
        logic [31:0] wide;
        wide = 32'(len);
        return wide[7:0];
    endfunction

endpackage

// ===== sv/integer_literal_scanner.sv =====
// Integer literal scanner, one character beat per cycle.
// Result: the outcome is written into the output register when the beat that ends
// the literal is accepted.
// Throughput: one input beat per cycle; s_ready drops only while a result is held
// and m_ready is low.
// Reset (aresetn low, synchronous): scan state returns to idle, the output is emptied.
module integer_literal_scanner (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ils_pkg::in_beat_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ils_pkg::out_beat_t   m_data
);
    import ils_pkg::*;

    phase_t      phase_reg,   phase_next;
    radix_t      radix_reg,   radix_next;
    logic [63:0] acc_reg,     acc_next;
    logic        seen_reg,    seen_next;
    cnt_t        cnt_reg,     cnt_next;
    logic        uns_reg,     uns_next;
    sfx_t        sfx_reg,     sfx_next;
    logic        m_valid_reg;
    out_beat_t   m_data_reg;

    logic        accept;
    logic        fin;
    status_t     fin_status;
    logic [6:0]  fin_width;
    cnt_t        fin_len;

    logic [7:0]  ch;
    logic        eoi;
    logic        full;
    cnt_t        cnt_inc;
    radix_t      rad_e;
    logic        seen_e;
    logic [4:0]  dval;
    logic        dv_ok;
    logic        is_dec;
    logic        is_sep;
    logic [63:0] acc_mac;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign ch      = s_data.ch;
    assign eoi     = s_data.end_of_input;
    assign full    = (32'(cnt_reg) >= MAX_LEN);
    assign cnt_inc = cnt_reg + cnt_t'(1);
    assign is_dec  = (ch >= "0") && (ch <= "9");
    assign is_sep  = (ch == " ") || (ch == ")") || (ch == ",") || (ch == ";") ||
                     (ch == ":") || (ch == 8'h0a) || (ch == 8'h0d);

    // Entering the digit run from a lone zero or a radix prefix starts with no digit seen.
    always_comb begin
        rad_e  = radix_reg;
        seen_e = seen_reg;
        if (phase_reg == PH_ZERO) begin
            rad_e  = RX_OCT;
            seen_e = 1'b0;
        end else if (phase_reg == PH_PREFIX) begin
            seen_e = 1'b0;
        end
    end

    always_comb begin
        dval = 5'h1f;
        if (is_dec) begin
            dval = 5'(ch - "0");
        end else if ((ch >= "a") && (ch <= "f")) begin
            dval = 5'(ch - "a") + 5'd10;
        end else if ((ch >= "A") && (ch <= "F")) begin
            dval = 5'(ch - "A") + 5'd10;
        end
        case (rad_e)
            RX_DEC:  dv_ok = (dval < 5'd10);
            RX_HEX:  dv_ok = (dval < 5'd16);
            RX_OCT:  dv_ok = (dval < 5'd8);
            RX_BIN:  dv_ok = (dval < 5'd2);
            default: dv_ok = 1'b0;
        endcase
    end

    // Multiply by the radix as shifts, then add the digit.
    always_comb begin
        case (rad_e)
            RX_DEC:  acc_mac = (acc_reg << 3) + (acc_reg << 1);
            RX_HEX:  acc_mac = acc_reg << 4;
            RX_OCT:  acc_mac = acc_reg << 3;
            RX_BIN:  acc_mac = acc_reg << 1;
            default: acc_mac = acc_reg;
        endcase
        acc_mac = acc_mac + 64'(dval[3:0]);
    end

    always_comb begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        cnt_next   = cnt_reg;
        uns_next   = uns_reg;
        sfx_next   = sfx_reg;
        fin        = 1'b0;
        fin_status = ST_INT;
        fin_width  = 7'd64;
        fin_len    = cnt_reg;

        case (phase_reg)
            PH_IDLE: begin
                if (!eoi) begin
                    if (ch == "0") begin
                        phase_next = PH_ZERO;
                        cnt_next   = cnt_t'(1);
                    end else if (is_dec) begin
                        radix_next = RX_DEC;
                        acc_next   = 64'(dval[3:0]);
                        seen_next  = 1'b1;
                        cnt_next   = cnt_t'(1);
                        phase_next = PH_DIGITS;
                    end else begin
                        fin        = 1'b1;
                        fin_status = ST_NOMATCH;
                        fin_len    = '0;
                    end
                end
            end
            PH_ZERO, PH_PREFIX, PH_DIGITS: begin
                if (phase_reg == PH_ZERO && eoi) begin
                    fin     = 1'b1;
                    fin_len = cnt_t'(1);
                end else if (phase_reg == PH_ZERO && (ch == "x" || ch == "b")) begin
                    radix_next = (ch == "x") ? RX_HEX : RX_BIN;
                    cnt_next   = cnt_t'(2);
                    phase_next = PH_PREFIX;
                end else if (phase_reg == PH_PREFIX && eoi) begin
                    fin        = 1'b1;
                    fin_status = ST_BAD;
                    fin_len    = cnt_t'(1);
                end else begin
                    radix_next = rad_e;
                    seen_next  = seen_e;
                    phase_next = PH_DIGITS;
                    if (eoi) begin
                        fin = 1'b1;
                    end else if (dv_ok) begin
                        if (full) begin
                            fin        = 1'b1;
                            fin_status = ST_BAD;
                        end else begin
                            acc_next  = acc_mac;
                            cnt_next  = cnt_inc;
                            seen_next = 1'b1;
                        end
                    end else if (ch == "_" && seen_e) begin
                        if (full) begin
                            fin        = 1'b1;
                            fin_status = ST_BAD;
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end else if (!seen_e && (rad_e == RX_HEX || rad_e == RX_BIN)) begin
                        fin        = 1'b1;
                        fin_status = ST_NOMATCH;
                        fin_len    = '0;
                    end else if (ch == "e" || ch == "E") begin
                        fin        = 1'b1;
                        fin_status = full ? ST_BAD : ST_FLOAT;
                        fin_len    = full ? cnt_reg : cnt_inc;
                    end else if (ch == ".") begin
                        if (full) begin
                            fin        = 1'b1;
                            fin_status = ST_BAD;
                        end else begin
                            cnt_next   = cnt_inc;
                            phase_next = PH_DOT;
                        end
                    end else if (is_sep) begin
                        fin = 1'b1;
                    end else if (ch == "u" || ch == "i") begin
                        if (full) begin
                            fin        = 1'b1;
                            fin_status = ST_BAD;
                        end else begin
                            uns_next   = (ch == "u");
                            cnt_next   = cnt_inc;
                            phase_next = PH_SUFFIX;
                        end
                    end else begin
                        fin        = 1'b1;
                        fin_status = ST_BAD;
                    end
                end
            end
            PH_DOT: begin
                fin = 1'b1;
                if (!eoi && is_dec) begin
                    fin_status = full ? ST_BAD : ST_FLOAT;
                    fin_len    = full ? cnt_reg : cnt_inc;
                end else begin
                    fin_status = ST_BAD;
                    fin_len    = cnt_reg - cnt_t'(1);
                end
            end
            PH_SUFFIX: begin
                if (eoi) begin
                    fin        = 1'b1;
                    fin_status = ST_BAD;
                end else if (ch == "8") begin
                    fin        = 1'b1;
                    fin_status = full ? ST_BAD : ST_INT;
                    fin_width  = 7'd8;
                    fin_len    = full ? cnt_reg : cnt_inc;
                end else if (ch == "1" || ch == "3" || ch == "6") begin
                    if (full) begin
                        fin        = 1'b1;
                        fin_status = ST_BAD;
                    end else begin
                        sfx_next   = (ch == "1") ? SFX_16 : (ch == "3") ? SFX_32 : SFX_64;
                        cnt_next   = cnt_inc;
                        phase_next = PH_SUFFIX2;
                    end
                end else begin
                    fin        = 1'b1;
                    fin_status = ST_BAD;
                end
            end
            PH_SUFFIX2: begin
                fin        = 1'b1;
                fin_status = ST_BAD;
                if (!eoi && ((sfx_reg == SFX_16 && ch == "6") ||
                             (sfx_reg == SFX_32 && ch == "2") ||
                             (sfx_reg != SFX_16 && sfx_reg != SFX_32 && ch == "4"))) begin
                    fin_status = full ? ST_BAD : ST_INT;
                    fin_len    = full ? cnt_reg : cnt_inc;
                    case (sfx_reg)
                        SFX_16:  fin_width = 7'd16;
                        SFX_32:  fin_width = 7'd32;
                        default: fin_width = 7'd64;
                    endcase
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (fin || phase_next == PH_IDLE) begin
            phase_next = PH_IDLE;
            radix_next = RX_DEC;
            acc_next   = '0;
            seen_next  = 1'b0;
            cnt_next   = '0;
            uns_next   = 1'b0;
            sfx_next   = SFX_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            radix_reg <= RX_DEC;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            cnt_reg   <= '0;
            uns_reg   <= 1'b0;
            sfx_reg   <= SFX_NONE;
        end else if (accept) begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
            uns_reg   <= uns_next;
            sfx_reg   <= sfx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && fin) begin
            m_data_reg.status          <= fin_status;
            m_data_reg.value           <= (fin_status == ST_INT) ? acc_reg : 64'd0;
            m_data_reg.is_unsigned     <= (fin_status == ST_INT) && uns_reg;
            m_data_reg.bit_width       <= (fin_status == ST_INT) ? fin_width : 7'd64;
            m_data_reg.consumed_length <= len8(fin_len);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
